// File: design/sktbl_pkg.sv
`timescale 1ns / 1ps

package sktbl_pkg;

  // Table sizes. The peer table takes the low entries of the key memory and
  // our table the entries after it.
  localparam int unsigned PEER_DEPTH  = 4;
  localparam int unsigned OWN_DEPTH   = 4;
  localparam int unsigned TOTAL_DEPTH = PEER_DEPTH + OWN_DEPTH;
  localparam int unsigned MAX_DEPTH   = (PEER_DEPTH > OWN_DEPTH) ? PEER_DEPTH : OWN_DEPTH;

  // A fill count must hold the depth itself.
  localparam int unsigned FILL_W  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ENTRY_W = $clog2(TOTAL_DEPTH);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic {
    TBL_PEER = 1'b0,
    TBL_OWN  = 1'b1
  } tbl_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e         operation;
    tbl_e        table_select;
    logic        addr_given;
    logic [1:0]  addr_kind;
    logic [47:0] peer_address;
    logic        ediv_rand_given;
    logic [15:0] ediv_value;
    logic [63:0] random_value;
    logic [1:0]  match_index;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        auth_flag;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  slot;
    logic [1:0]  found_addr_kind;
    logic [47:0] found_address;
    logic [15:0] found_ediv;
    logic [63:0] found_random;
    logic [63:0] found_key_high;
    logic [63:0] found_key_low;
    logic        found_auth;
  } out_t;

  // One word of the key memory.
  typedef struct packed {
    logic [1:0]  addr_kind;
    logic [47:0] address;
    logic [15:0] ediv;
    logic [63:0] random;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        auth;
  } entry_t;

  // Memory address of a table position.
  function automatic logic [ENTRY_W-1:0] entry_addr(input tbl_e sel,
                                                    input logic [FILL_W-1:0] pos);
    logic [7:0] sum;
    sum = ((sel == TBL_OWN) ? 8'(PEER_DEPTH) : 8'd0) + 8'(pos);
    return ENTRY_W'(sum);
  endfunction

endpackage

// File: design/security_key_table_unit.sv
`timescale 1ns / 1ps

// Security key table. Holds the bonding keys of the peer table and of our
// table in one key memory with a registered read port. A request is taken
// while the block is idle; the block then reads the filled entries of the
// selected table one per cycle, comparing each entry the cycle after its
// read, and stops at the requested match or after the last filled entry.
// Writes update the memory in the cycle the scan ends. A new request can
// be taken once the result has been loaded into the output register,
// while that result still waits at the output.
module security_key_table_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sktbl_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sktbl_pkg::out_t out_data_o
);
  import sktbl_pkg::*;

  state_e              state_q, state_d;
  in_t                 req_q, req_d;
  logic [1:0]          nth_q, nth_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [FILL_W-1:0]   rd_idx_q, rd_idx_d;
  logic [FILL_W-1:0]   pos_q, pos_d;
  logic                pend_q, pend_d;
  logic [FILL_W-1:0]   peer_fill_q, peer_fill_d;
  logic [FILL_W-1:0]   own_fill_q, own_fill_d;
  out_t                res_q, res_d;
  out_t                out_q;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  entry_t              key_mem [TOTAL_DEPTH];
  entry_t              rdata_q;
  logic                mem_re, mem_we;
  logic [ENTRY_W-1:0]  mem_raddr, mem_waddr;
  entry_t              mem_wdata;

  logic [FILL_W-1:0]   cur_fill;
  logic [FILL_W-1:0]   cur_depth;
  logic                addr_ok, er_ok, match, found, miss;

  // Fill count and depth of the table the request selects.
  assign cur_fill  = (req_q.table_select == TBL_OWN) ? own_fill_q : peer_fill_q;
  assign cur_depth = (req_q.table_select == TBL_OWN) ? FILL_W'(OWN_DEPTH)
                                                     : FILL_W'(PEER_DEPTH);

  // Criteria checks on the entry read in the previous cycle.
  assign addr_ok = !req_q.addr_given ||
                   (rdata_q.addr_kind == req_q.addr_kind &&
                    rdata_q.address == req_q.peer_address);
  assign er_ok   = !req_q.ediv_rand_given ||
                   (rdata_q.ediv == req_q.ediv_value &&
                    rdata_q.random == req_q.random_value);
  assign match   = pend_q && addr_ok && er_ok;
  assign found   = match && (cnt_q == nth_q);
  assign miss    = !pend_q && (rd_idx_q >= cur_fill);

  // The whole entry is replaced by the request fields on a write.
  assign mem_wdata = '{addr_kind: req_q.addr_kind,
                       address:   req_q.peer_address,
                       ediv:      req_q.ediv_value,
                       random:    req_q.random_value,
                       key_high:  req_q.key_high,
                       key_low:   req_q.key_low,
                       auth:      req_q.auth_flag};

  // Sequencer: accept, scan with one read in flight per cycle, then finish.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    nth_d       = nth_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    pos_d       = pos_q;
    pend_d      = 1'b0;
    peer_fill_d = peer_fill_q;
    own_fill_d  = own_fill_q;
    res_d       = res_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = entry_addr(req_q.table_select, rd_idx_q);
    mem_waddr   = entry_addr(req_q.table_select, pos_q);
    out_load    = 1'b0;
    in_stall_o  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d    = in_data_i;
          nth_d    = (in_data_i.operation == OP_WRITE) ? 2'd0 : in_data_i.match_index;
          cnt_d    = 2'd0;
          rd_idx_d = '0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (match && !found) begin
          cnt_d = cnt_q + 2'd1;
        end
        if (found || miss) begin
          res_d   = '0;
          state_d = S_DONE;
          if (req_q.operation == OP_READ) begin
            if (found) begin
              res_d.status          = ST_OK;
              res_d.slot            = 2'(pos_q);
              res_d.found_addr_kind = rdata_q.addr_kind;
              res_d.found_address   = rdata_q.address;
              res_d.found_ediv      = rdata_q.ediv;
              res_d.found_random    = rdata_q.random;
              res_d.found_key_high  = rdata_q.key_high;
              res_d.found_key_low   = rdata_q.key_low;
              res_d.found_auth      = rdata_q.auth;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end else if (found) begin
            // Overwrite the first matching entry.
            mem_we       = 1'b1;
            res_d.status = ST_OK;
            res_d.slot   = 2'(pos_q);
          end else if (cur_fill >= cur_depth) begin
            res_d.status = ST_FULL;
          end else begin
            // Append after the last filled entry.
            mem_we       = 1'b1;
            mem_waddr    = entry_addr(req_q.table_select, cur_fill);
            res_d.status = ST_OK;
            res_d.slot   = 2'(cur_fill);
            if (req_q.table_select == TBL_OWN) begin
              own_fill_d = own_fill_q + FILL_W'(1);
            end else begin
              peer_fill_d = peer_fill_q + FILL_W'(1);
            end
          end
        end else if (rd_idx_q < cur_fill) begin
          // Issue the read of the next filled entry.
          mem_re   = 1'b1;
          pos_d    = rd_idx_q;
          rd_idx_d = rd_idx_q + FILL_W'(1);
          pend_d   = 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 2'd0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      peer_fill_q <= '0;
      own_fill_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      peer_fill_q <= peer_fill_d;
      own_fill_q  <= own_fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    nth_q <= nth_d;
    pos_q <= pos_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Key memory with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= key_mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // Neither table grows past its depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (peer_fill_q <= FILL_W'(PEER_DEPTH)) && (own_fill_q <= FILL_W'(OWN_DEPTH)))
    else $error("key table fill count exceeds its depth");

  // The peer fill count only ever moves up by one entry.
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (peer_fill_q != $past(peer_fill_q)) |->
      (peer_fill_q == $past(peer_fill_q) + FILL_W'(1)))
    else $error("peer fill count changed by more than one");

  // The match counter never passes the requested match during a scan.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= nth_q))
    else $error("match counter passed the requested match");

  // A result only appears after the finish state.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result valid without a finished request");
`endif

endmodule

// File: test/security_key_table_unit_tb.sv
`timescale 1ns / 1ps

module security_key_table_unit_tb;
  import sktbl_pkg::*;

  // Keeps its own copy of both key tables and the answers still owed.
  class key_table_scoreboard;
    entry_t entries[TOTAL_DEPTH];
    int     fill[2];
    out_t   pending_answers[$];
    int     failures;

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    // Position within the table of the nth entry that passes the enabled
    // criteria, or -1 if there is no such entry.
    function int find_match(in_t req, int nth);
      int     base;
      int     t;
      int     passed;
      entry_t ent;
      t      = (req.table_select == TBL_OWN) ? 1 : 0;
      base   = (t == 1) ? PEER_DEPTH : 0;
      passed = 0;
      for (int i = 0; i < fill[t]; i++) begin
        ent = entries[base + i];
        if (req.addr_given &&
            {ent.addr_kind, ent.address} != {req.addr_kind, req.peer_address}) continue;
        if (req.ediv_rand_given &&
            (ent.ediv != req.ediv_value || ent.random != req.random_value)) continue;
        if (passed == nth) return i;
        passed++;
      end
      return -1;
    endfunction

    // Applies an accepted request to the tables and queues its answer.
    function void note_request(in_t req);
      out_t ans;
      int   t;
      int   base;
      int   depth;
      int   pos;
      ans   = '0;
      t     = (req.table_select == TBL_OWN) ? 1 : 0;
      base  = (t == 1) ? PEER_DEPTH : 0;
      depth = (t == 1) ? OWN_DEPTH : PEER_DEPTH;
      if (req.operation == OP_READ) begin
        pos = find_match(req, int'(req.match_index));
        if (pos < 0) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          ans.status          = ST_OK;
          ans.slot            = 2'(pos);
          ans.found_addr_kind = entries[base + pos].addr_kind;
          ans.found_address   = entries[base + pos].address;
          ans.found_ediv      = entries[base + pos].ediv;
          ans.found_random    = entries[base + pos].random;
          ans.found_key_high  = entries[base + pos].key_high;
          ans.found_key_low   = entries[base + pos].key_low;
          ans.found_auth      = entries[base + pos].auth;
        end
      end else begin
        // A write always looks for the first match, whatever match_index says.
        pos = find_match(req, 0);
        if (pos < 0 && fill[t] >= depth) begin
          ans.status = ST_FULL;
        end else begin
          if (pos < 0) begin
            pos = fill[t];
            fill[t]++;
          end
          entries[base + pos].addr_kind = req.addr_kind;
          entries[base + pos].address   = req.peer_address;
          entries[base + pos].ediv      = req.ediv_value;
          entries[base + pos].random    = req.random_value;
          entries[base + pos].key_high  = req.key_high;
          entries[base + pos].key_low   = req.key_low;
          entries[base + pos].auth      = req.auth_flag;
          ans.status = ST_OK;
          ans.slot   = 2'(pos);
        end
      end
      pending_answers.push_back(ans);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) note_failure($sformatf("%s expected %h, got %h", name, want, got));
    endfunction

    // Compares one delivered answer with the oldest one owed.
    function void check_answer(out_t got);
      out_t want;
      if (pending_answers.size() == 0) begin
        note_failure($sformatf("answer with none outstanding: %h", got));
        return;
      end
      want = pending_answers.pop_front();
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("slot", 64'(want.slot), 64'(got.slot));
      check_field("found_addr_kind", 64'(want.found_addr_kind), 64'(got.found_addr_kind));
      check_field("found_address", 64'(want.found_address), 64'(got.found_address));
      check_field("found_ediv", 64'(want.found_ediv), 64'(got.found_ediv));
      check_field("found_random", want.found_random, got.found_random);
      check_field("found_key_high", want.found_key_high, got.found_key_high);
      check_field("found_key_low", want.found_key_low, got.found_key_low);
      check_field("found_auth", 64'(want.found_auth), 64'(got.found_auth));
    endfunction
  endclass

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  key_table_scoreboard sb = new();
  bit                  idle_on;
  entry_t              pool[2][6];

  security_key_table_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic entry_t random_entry();
    entry_t ent;
    ent.addr_kind = 2'($urandom);
    ent.address   = 48'(rand64());
    ent.ediv      = 16'($urandom);
    ent.random    = rand64();
    ent.key_high  = rand64();
    ent.key_low   = rand64();
    ent.auth      = 1'($urandom);
    return ent;
  endfunction

  function automatic in_t make_request(op_e op, tbl_e tbl, bit addr_on, bit er_on,
                                       logic [1:0] nth, entry_t ent);
    in_t req;
    req.operation       = op;
    req.table_select    = tbl;
    req.addr_given      = addr_on;
    req.addr_kind       = ent.addr_kind;
    req.peer_address    = ent.address;
    req.ediv_rand_given = er_on;
    req.ediv_value      = ent.ediv;
    req.random_value    = ent.random;
    req.match_index     = nth;
    req.key_high        = ent.key_high;
    req.key_low         = ent.key_low;
    req.auth_flag       = ent.auth;
    return req;
  endfunction

  // Most requests reuse a small set of identities so that lookups hit stored
  // entries; some mix the address of one with the ediv of another, and a few
  // are fully random.
  function automatic in_t random_request();
    entry_t ent;
    int     t;
    int     a;
    int     b;
    t   = $urandom_range(0, 1);
    ent = random_entry();
    if ($urandom_range(0, 7) != 0) begin
      a = $urandom_range(0, 5);
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : a;
      ent.addr_kind = pool[t][a].addr_kind;
      ent.address   = pool[t][a].address;
      ent.ediv      = pool[t][b].ediv;
      ent.random    = pool[t][b].random;
    end
    return make_request(($urandom_range(0, 9) < 4) ? OP_WRITE : OP_READ,
                        (t == 1) ? TBL_OWN : TBL_PEER, 1'($urandom), 1'($urandom),
                        2'($urandom), ent);
  endfunction

  // Offers one request, sometimes after a random gap, and waits for its acceptance.
  task automatic send_request(in_t req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic wait_all_answered();
    while (sb.pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // Result side: check on every accepted answer and stall in random bursts.
  always @(posedge clk_i) begin
    int stall_left;
    if (rst_ni && out_valid && !out_stall) sb.check_answer(out_data);
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    out_stall <= (stall_left > 0);
  end

  // Stimulus.
  initial begin
    entry_t ones;
    entry_t zeros;
    entry_t ids[8];
    ones  = '1;
    zeros = '0;
    for (int i = 0; i < 8; i++) ids[i] = random_entry();
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < 6; i++) pool[t][i] = random_entry();
    end
    idle_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lookups in empty tables find nothing.
    send_request(make_request(OP_READ, TBL_PEER, 1'b0, 1'b0, 2'd0, zeros));
    send_request(make_request(OP_READ, TBL_OWN, 1'b1, 1'b1, 2'd3, ones));
    // Extreme values appended to the peer table, then looked up.
    send_request(make_request(OP_WRITE, TBL_PEER, 1'b1, 1'b1, 2'd3, ones));
    send_request(make_request(OP_WRITE, TBL_PEER, 1'b1, 1'b1, 2'd0, zeros));
    send_request(make_request(OP_READ, TBL_PEER, 1'b0, 1'b0, 2'd1, ids[0]));
    send_request(make_request(OP_READ, TBL_PEER, 1'b0, 1'b0, 2'd2, ids[0]));
    send_request(make_request(OP_READ, TBL_PEER, 1'b1, 1'b0, 2'd0, ones));
    send_request(make_request(OP_READ, TBL_PEER, 1'b0, 1'b1, 2'd0, zeros));
    // A write with no criteria overwrites the first entry in full.
    send_request(make_request(OP_WRITE, TBL_PEER, 1'b0, 1'b0, 2'd3, ids[0]));
    send_request(make_request(OP_READ, TBL_PEER, 1'b0, 1'b0, 2'd0, zeros));
    // Fill the peer table, then overflow it.
    send_request(make_request(OP_WRITE, TBL_PEER, 1'b1, 1'b0, 2'd1, ids[1]));
    send_request(make_request(OP_WRITE, TBL_PEER, 1'b1, 1'b1, 2'd2, ids[2]));
    send_request(make_request(OP_WRITE, TBL_PEER, 1'b1, 1'b0, 2'd0, ids[3]));
    send_request(make_request(OP_READ, TBL_PEER, 1'b0, 1'b0, 2'd3, zeros));
    send_request(make_request(OP_READ, TBL_PEER, 1'b1, 1'b1, 2'd0, ids[2]));
    ids[4]      = ids[2];
    ids[4].ediv = ~ids[2].ediv;
    send_request(make_request(OP_READ, TBL_PEER, 1'b1, 1'b1, 2'd0, ids[4]));
    // Fill our table by ediv and random only, then overflow and look up.
    for (int i = 4; i < 8; i++) begin
      send_request(make_request(OP_WRITE, TBL_OWN, 1'b0, 1'b1, 2'd2, ids[i]));
    end
    send_request(make_request(OP_WRITE, TBL_OWN, 1'b0, 1'b1, 2'd0, ids[0]));
    send_request(make_request(OP_READ, TBL_OWN, 1'b0, 1'b1, 2'd0, ids[6]));
    send_request(make_request(OP_READ, TBL_OWN, 1'b0, 1'b0, 2'd3, zeros));
    send_request(make_request(OP_READ, TBL_OWN, 1'b1, 1'b0, 2'd0, ids[7]));

    // Hold the sender until everything is answered.
    in_valid <= 1'b0;
    wait_all_answered();

    // Random part: idling comes and goes in stretches, none near the end.
    for (int n = 0; n < 1280; n++) begin
      idle_on = (n < 1100) && ((n / 150) % 2 == 0);
      if (n == 640) begin
        in_valid <= 1'b0;
        wait_all_answered();
      end
      send_request(random_request());
    end
    in_valid <= 1'b0;

    wait_all_answered();
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
